### src/ehc_pkg.sv
// Package for the extended Hamming SECDED codec: block geometry, opcode and
// status codes, and the bit scatter/gather and syndrome helpers.
// No dependencies.
package ehc_pkg;

    localparam int BLOCK_BITS = 64;
    localparam int POS_W      = $clog2(BLOCK_BITS);
    localparam int DATA_W     = 57;
    localparam int CFG_W      = 6;
    localparam logic [CFG_W-1:0] DATA_CAP = CFG_W'(DATA_W);

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_CHECK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0] syn;
        logic             par;
    } t_syn;

    function automatic logic is_pow2(int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Data bit k goes to the k-th non-power-of-two position above zero.
    function automatic logic [BLOCK_BITS-1:0] scatter(logic [DATA_W-1:0] d);
        logic [BLOCK_BITS-1:0] w;
        int                    k;
        w = '0;
        k = 0;
        for (int p = 1; p < BLOCK_BITS; p++) begin
            if (!is_pow2(p)) begin
                w[p] = d[k];
                k++;
            end
        end
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] gather(logic [BLOCK_BITS-1:0] w);
        logic [DATA_W-1:0] d;
        int                k;
        d = '0;
        k = 0;
        for (int p = 1; p < BLOCK_BITS; p++) begin
            if (!is_pow2(p)) begin
                d[k] = w[p];
                k++;
            end
        end
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] used_mask(logic [CFG_W-1:0] u);
        logic [DATA_W-1:0] m;
        for (int k = 0; k < DATA_W; k++) begin
            m[k] = (k < int'(u));
        end
        return m;
    endfunction

    // Positions whose index has bit b set.
    function automatic logic [BLOCK_BITS-1:0] pos_mask(int b);
        logic [BLOCK_BITS-1:0] m;
        for (int p = 0; p < BLOCK_BITS; p++) begin
            m[p] = ((p >> b) & 1) != 0;
        end
        return m;
    endfunction

    function automatic logic [POS_W-1:0] syndrome(logic [BLOCK_BITS-1:0] w);
        logic [POS_W-1:0] s;
        for (int b = 0; b < POS_W; b++) begin
            s[b] = ^(w & pos_mask(b));
        end
        return s;
    endfunction

endpackage

### src/ehc_syndrome.sv
// Syndrome and overall parity of one block: XOR of the indices of set bits
// and the count of ones mod 2. Depends on ehc_pkg.
module ehc_syndrome (
    input  logic [ehc_pkg::BLOCK_BITS-1:0] i_word,
    output ehc_pkg::t_syn                  o_syn
);
    import ehc_pkg::*;

    always_comb begin
        o_syn.syn = syndrome(i_word);
        o_syn.par = ^i_word;
    end

endmodule

### src/extended_hamming_secded_codec_unit.sv
// Extended Hamming SECDED (64,57) codec unit: top level with the four-stage
// pipeline and the data count register. Depends on ehc_pkg, ehc_syndrome.
//
// Takes one beat per clock: a beat enters whenever start is high and busy is
// low, and busy is high only while reset is asserted. Each beat yields one
// result, shown for exactly one cycle with o_done high; the receiver cannot
// stall. The four stages are: scatter of data bits into the block or
// pass-through of a received block, syndrome and parity trees, parity insertion
// or single-bit correction, and data extraction into the output register. The
// data count register saturates at 57 and must only be written while no beat
// is in flight.
module extended_hamming_secded_codec_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ehc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [63:0]                   i_word_in,
    output logic                          o_done,
    output logic [63:0]                   o_code_word,
    output logic [ehc_pkg::DATA_W-1:0]    o_data_out,
    output logic [1:0]                    o_status,
    output logic [ehc_pkg::POS_W-1:0]     o_error_position
);
    import ehc_pkg::*;

    logic [CFG_W-1:0]      r_used;
    logic [CFG_W-1:0]      n_used;

    logic                  r_v1, r_v2, r_v3, r_v4;
    t_op                   r_op1, r_op2;
    logic [BLOCK_BITS-1:0] r_cw1, r_cw2, r_cw3;
    t_syn                  r_syn2;
    t_status               r_st3;
    logic [POS_W-1:0]      r_pos3;

    logic [BLOCK_BITS-1:0] n_cw1;
    t_syn                  s1_syn;
    logic [BLOCK_BITS-1:0] n_cw3;
    t_status               n_st3;
    logic [POS_W-1:0]      n_pos3;

    logic [BLOCK_BITS-1:0] r_out_cw;
    logic [DATA_W-1:0]     r_out_data;
    t_status               r_out_st;
    logic [POS_W-1:0]      r_out_pos;

    logic                  take;

    assign busy = ~i_rst_n;
    assign take = start & ~busy;

    assign n_used = (i_cfg_data > DATA_CAP) ? DATA_CAP : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= DATA_CAP;
        end else if (i_cfg_we) begin
            r_used <= n_used;
        end
    end

    // Stage 1: place data bits or pass the received block.
    always_comb begin
        if (t_op'(i_opcode) == OP_CHECK) begin
            n_cw1 = i_word_in[BLOCK_BITS-1:0];
        end else begin
            n_cw1 = scatter(i_word_in[DATA_W-1:0] & used_mask(r_used));
        end
    end

    // Stage 2 input: syndrome and parity of the stage 1 block.
    ehc_syndrome u_syn (
        .i_word (r_cw1),
        .o_syn  (s1_syn)
    );

    // Stage 3: insert parity bits, or correct a single error.
    always_comb begin
        n_cw3  = r_cw2;
        n_st3  = ST_OK;
        n_pos3 = '0;
        if (r_op2 == OP_ENCODE) begin
            for (int b = 0; b < POS_W; b++) begin
                n_cw3[1 << b] = r_syn2.syn[b];
            end
            n_cw3[0] = r_syn2.par ^ (^r_syn2.syn);
        end else begin
            priority if (r_syn2.syn == '0) begin
                if (r_syn2.par) begin
                    n_cw3[0] = ~r_cw2[0];
                    n_st3    = ST_SINGLE;
                end
            end else if (r_syn2.par) begin
                n_cw3[r_syn2.syn] = ~r_cw2[r_syn2.syn];
                n_st3             = ST_SINGLE;
                n_pos3            = r_syn2.syn;
            end else begin
                n_st3 = ST_DOUBLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload advances every cycle; valid bits mark which beats are real.
    always_ff @(posedge i_clk) begin
        r_op1      <= t_op'(i_opcode);
        r_cw1      <= n_cw1;
        r_op2      <= r_op1;
        r_cw2      <= r_cw1;
        r_syn2     <= s1_syn;
        r_cw3      <= n_cw3;
        r_st3      <= n_st3;
        r_pos3     <= n_pos3;
        r_out_cw   <= r_cw3;
        r_out_data <= gather(r_cw3) & used_mask(r_used);
        r_out_st   <= r_st3;
        r_out_pos  <= r_pos3;
    end

    assign o_done           = r_v4;
    assign o_code_word      = 64'(r_out_cw);
    assign o_data_out       = r_out_data;
    assign o_status         = r_out_st;
    assign o_error_position = r_out_pos;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##4 o_done)
        else $error("accepted beat did not yield a result after four cycles");

    a_pos_only_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_out_st != ST_SINGLE) |-> (o_error_position == '0))
        else $error("error position set without a single-error correction");

    a_even_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_out_st != ST_DOUBLE) |-> (^r_out_cw == 1'b0))
        else $error("delivered block does not have even parity");

    a_zero_syndrome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_out_st != ST_DOUBLE) |-> (syndrome(r_out_cw) == '0))
        else $error("delivered block has nonzero syndrome");
`endif

endmodule

### tb/tb_extended_hamming_secded_codec_unit.sv
// Self-checking testbench for the extended Hamming SECDED codec unit.
// Depends on ehc_pkg and extended_hamming_secded_codec_unit; it has its own
// encode/check predictor and mixes directed rows with random encode and check beats.
module tb_extended_hamming_secded_codec_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ehc_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          STALL_LIMIT = 1000;
    localparam int          PHASE_BEATS = 80;
    localparam int          NUM_PHASES  = 7;
    localparam logic [63:0] ONES64      = {64{1'b1}};
    localparam logic [DATA_W-1:0] DATA_ONES = {DATA_W{1'b1}};

    typedef struct packed {
        logic [63:0]       cw;
        logic [DATA_W-1:0] data;
        t_status           st;
        logic [POS_W-1:0]  pos;
    } codec_result_t;

    typedef struct packed {
        t_op           op;
        logic [63:0]   word;
        logic          typed;
        codec_result_t res;
    } directed_row_t;

    // Typed rows assume the reset data count of 57.
    localparam directed_row_t DIRECTED_ROWS [22] = '{
        '{OP_ENCODE, 64'h0, 1'b1, '{64'h0, 57'h0, ST_OK, 6'd0}},
        '{OP_ENCODE, ONES64, 1'b0, '0},
        '{OP_ENCODE, 64'h1, 1'b1, '{64'hF, 57'h1, ST_OK, 6'd0}},
        '{OP_ENCODE, 64'h0100_0000_0000_0000, 1'b0, '0},
        // bit above the data count is dropped
        '{OP_ENCODE, 64'h0200_0000_0000_0000, 1'b1, '{64'h0, 57'h0, ST_OK, 6'd0}},
        '{OP_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{OP_ENCODE, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{OP_CHECK, 64'h0, 1'b1, '{64'h0, 57'h0, ST_OK, 6'd0}},
        '{OP_CHECK, ONES64, 1'b1, '{ONES64, DATA_ONES, ST_OK, 6'd0}},
        '{OP_CHECK, 64'hF, 1'b1, '{64'hF, 57'h1, ST_OK, 6'd0}},
        // overall parity bit flipped
        '{OP_CHECK, 64'hE, 1'b1, '{64'hF, 57'h1, ST_SINGLE, 6'd0}},
        '{OP_CHECK, 64'h7, 1'b1, '{64'hF, 57'h1, ST_SINGLE, 6'd3}},
        '{OP_CHECK, 64'h5, 1'b1, '{64'h5, 57'h0, ST_DOUBLE, 6'd0}},
        '{OP_CHECK, 64'h1, 1'b1, '{64'h0, 57'h0, ST_SINGLE, 6'd0}},
        '{OP_CHECK, 64'h8000_0000_0000_0000, 1'b1, '{64'h0, 57'h0, ST_SINGLE, 6'd63}},
        '{OP_CHECK, 64'h6, 1'b1, '{64'h6, 57'h0, ST_DOUBLE, 6'd0}},
        '{OP_CHECK, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{ONES64, DATA_ONES, ST_SINGLE, 6'd63}},
        '{OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFC, DATA_ONES, ST_DOUBLE, 6'd0}},
        '{OP_CHECK, 64'h8000_0000_0000_0001, 1'b1,
          '{64'h8000_0000_0000_0001, 57'h100_0000_0000_0000, ST_DOUBLE, 6'd0}},
        '{OP_CHECK, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{OP_CHECK, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{OP_ENCODE, 64'h0123_4567_89AB_CDEF, 1'b0, '0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_opcode = 1'b0;
    logic [63:0]          i_word_in = '0;
    logic                 o_done;
    logic [63:0]          o_code_word;
    logic [DATA_W-1:0]    o_data_out;
    logic [1:0]           o_status;
    logic [POS_W-1:0]     o_error_position;

    codec_result_t        due_results[$];
    logic [CFG_W-1:0]     data_count = DATA_CAP;
    int unsigned          idle_pct = 0;
    int unsigned          mismatches = 0;
    int unsigned          stall_cycles = 0;
    int unsigned          n_encode = 0;
    int unsigned          n_check = 0;
    int unsigned          n_single = 0;
    int unsigned          n_double = 0;

    extended_hamming_secded_codec_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_word_in        (i_word_in),
        .o_done           (o_done),
        .o_code_word      (o_code_word),
        .o_data_out       (o_data_out),
        .o_status         (o_status),
        .o_error_position (o_error_position)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic parity_slot(int p);
        return (p & (p - 1)) == 0;
    endfunction

    function automatic int unsigned active_bits(logic [CFG_W-1:0] cfg);
        return (int'(cfg) > DATA_W) ? DATA_W : int'(cfg);
    endfunction

    function automatic logic [POS_W-1:0] index_xor(logic [63:0] w);
        logic [POS_W-1:0] s;
        s = '0;
        for (int p = 0; p < BLOCK_BITS; p++) begin
            if (w[p]) s ^= POS_W'(p);
        end
        return s;
    endfunction

    function automatic logic [63:0] encode_block(logic [63:0] d, logic [CFG_W-1:0] cfg);
        logic [63:0]      cw;
        logic [POS_W-1:0] s;
        int unsigned      k;
        cw = '0;
        k = 0;
        for (int p = 1; p < BLOCK_BITS; p++) begin
            if (!parity_slot(p) && k < active_bits(cfg)) begin
                cw[p] = d[k];
                k++;
            end
        end
        s = index_xor(cw);
        for (int b = 0; b < POS_W; b++) begin
            if (s[b]) cw[1 << b] = 1'b1;
        end
        cw[0] = ^cw;
        return cw;
    endfunction

    function automatic logic [DATA_W-1:0] pull_data(logic [63:0] cw, logic [CFG_W-1:0] cfg);
        logic [DATA_W-1:0] d;
        int unsigned       k;
        d = '0;
        k = 0;
        for (int p = 1; p < BLOCK_BITS; p++) begin
            if (!parity_slot(p) && k < active_bits(cfg)) begin
                d[k] = cw[p];
                k++;
            end
        end
        return d;
    endfunction

    function automatic codec_result_t codec_predict(t_op op, logic [63:0] word,
                                                    logic [CFG_W-1:0] cfg);
        codec_result_t    r;
        logic [POS_W-1:0] s;
        r = '0;
        r.st = ST_OK;
        if (op == OP_ENCODE) begin
            r.cw = encode_block(word, cfg);
        end else begin
            r.cw = word;
            s = index_xor(word);
            if (s == '0) begin
                if (^word) begin
                    r.cw[0] = ~r.cw[0];
                    r.st = ST_SINGLE;
                end
            end else if (^word) begin
                r.cw[s] = ~r.cw[s];
                r.st = ST_SINGLE;
                r.pos = s;
            end else begin
                r.st = ST_DOUBLE;
            end
        end
        r.data = pull_data(r.cw, cfg);
        return r;
    endfunction

    // Present one beat after a random idle stretch and hold it until accepted.
    task automatic issue_beat(input t_op op, input logic [63:0] word,
                              input logic typed, input codec_result_t typed_r);
        codec_result_t want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_opcode <= 1'($urandom_range(1));
            i_word_in <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_word_in <= word;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        want = typed ? typed_r : codec_predict(op, word, data_count);
        due_results.push_back(want);
        if (op == OP_ENCODE) n_encode++;
        else n_check++;
        if (want.st == ST_SINGLE) n_single++;
        if (want.st == ST_DOUBLE) n_double++;
    endtask

    // Encode beats of random data, check beats of valid code words with up to three flipped bits, and raw noise checks.
    task automatic random_beat();
        logic [63:0]   data;
        logic [63:0]   flips;
        int unsigned   roll;
        int unsigned   nflip;
        int unsigned   p;
        codec_result_t blank;
        blank = '0;
        data = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 30) begin
            issue_beat(OP_ENCODE, data, 1'b0, blank);
        end else if (roll < 85) begin
            flips = '0;
            p = $urandom_range(19);
            nflip = (p < 5) ? 0 : (p < 12) ? 1 : (p < 18) ? 2 : 3;
            for (int i = 0; i < nflip; i++) begin
                p = $urandom_range(63);
                while (flips[p]) p = $urandom_range(63);
                flips[p] = 1'b1;
            end
            issue_beat(OP_CHECK, encode_block(data, data_count) ^ flips, 1'b0, blank);
        end else begin
            issue_beat(OP_CHECK, data, 1'b0, blank);
        end
    endtask

    // Change the data count only with the pipeline drained.
    task automatic write_count(input logic [CFG_W-1:0] value);
        while (due_results.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        data_count = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        codec_result_t want;
        if (o_done === 1'b1) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, code_word %h", $time, o_code_word);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                report_field("code_word", want.cw, o_code_word);
                report_field("data_out", 64'(want.data), 64'(o_data_out));
                report_field("status", 64'(want.st), 64'(o_status));
                report_field("error_position", 64'(want.pos), 64'(o_error_position));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || o_done === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, due_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] count_plan [NUM_PHASES];
        count_plan = '{6'd63, 6'd0, 6'd1, 6'd58, 6'd28, 6'd0, 6'd57};
        count_plan[5] = CFG_W'($urandom_range(63));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 12;
        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            issue_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].word,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            start <= 1'b0;
            write_count(count_plan[ph]);
            idle_pct = (ph < 2) ? 12 : (ph < 4) ? 85 : 0;
            repeat (PHASE_BEATS) random_beat();
        end

        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d encode and %0d check beats: %0d single corrections, %0d double errors",
                 n_encode, n_check, n_single, n_double);
        $display("Data count swept over 0, 1, 28, 57, 58, 63 and a random value at three idle rates");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
